/* rtl/core/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the point list engine
// Operation and reply codes, status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int REPLY_W  = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int RADIUS_W = 16;

    // parameter defaults
    localparam int DEF_CAPACITY    = 32;
    localparam int DEF_COORD_WIDTH = 16;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd5;

    // reply codes
    localparam logic [REPLY_W-1:0] REPLY_ACK      = 3'd0;
    localparam logic [REPLY_W-1:0] REPLY_IN_RANGE = 3'd1;
    localparam logic [REPLY_W-1:0] REPLY_NONE     = 3'd2;
    localparam logic [REPLY_W-1:0] REPLY_FIND     = 3'd3;
    localparam logic [REPLY_W-1:0] REPLY_COUNT    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPLY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted request
        logic scan;     // walk the stored points
        logic finish;   // emit the closing result and commit the update
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/point_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_list_engine: ordered point store with radius query
// Newest-first store of signed points with push, pop, delete, radius list,
// find and count operations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid / in_stall with kind, x_coord, y_coord and
//   radius; a request is taken when in_valid is high and in_stall is low.
//   Results leave on out_valid / out_stall; last marks the closing result of
//   each request. A radius query gives one result per point in range, front
//   to back, or a single "no point" result.
//   One request is in flight at a time. Push, pop and count, and delete,
//   find or radius query on an empty store, go straight to the reply state,
//   which loads their result once the output register is free. Otherwise
//   delete and find walk the stored points through the single read port of
//   the store, one entry per cycle while the walk is not paused, and then
//   load the closing result from the reply state; a radius query has one
//   more stage for the squares. The next request is taken the cycle after that load.
//   A stalled receiver holds the output register; a walk pauses only when a
//   further in-range point needs the register, and the next request waits
//   until the closing result has been loaded.
//   Reset empties the store at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module point_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [KIND_W-1:0]             kind,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic [RADIUS_W-1:0]           radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [REPLY_W-1:0]            reply,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic                          found,
    output logic [COUNT_W-1:0]            count,
    output logic [STATUS_W-1:0]           status,
    output logic                          last
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // sequencer
    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (cmd)
    );

    // store and walk datapath
    ple_datapath #(
        .CAPACITY    (CAPACITY),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (dp_status),
        .kind        (kind),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .radius      (radius),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reply       (reply),
        .x_out       (x_out),
        .y_out       (y_out),
        .found       (found),
        .count       (count),
        .status_code (status),
        .last        (last)
    );

endmodule

/* rtl/core/ple_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl: request sequencer
// Accepts one request at a time, runs the store walk when the operation
// needs one, then hands the closing result to the output register.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] kind,
    output logic              in_stall,
    input  dp_status_t        status,
    output ctrl_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        KIND_PUSH, KIND_POP, KIND_COUNT:
                        begin
                            state_next = ST_REPLY;
                        end
                        KIND_DELETE, KIND_QUERY, KIND_FIND:
                        begin
                            state_next = status.empty ? ST_REPLY : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;   // unused codes are dropped
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_REPLY:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/ple_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_datapath: point store, walk pipeline and output register
// The store is a circular buffer addressed from a head pointer. A walk reads one
// entry per cycle while not paused; delete compacts behind the match in the same
// pass and the radius test squares the coordinates one stage after the read.
// ----------------------------------------------------------------------------
module ple_datapath
    import ple_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_cmd_t                     cmd,
    output dp_status_t                    status,
    input  logic [KIND_W-1:0]             kind,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic [RADIUS_W-1:0]           radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [REPLY_W-1:0]            reply,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic                          found,
    output logic [COUNT_W-1:0]            count,
    output logic [STATUS_W-1:0]           status_code,
    output logic                          last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int R2_W  = 2 * RADIUS_W;
    localparam int CMP_W = (SQ_W + 9 > R2_W) ? SQ_W + 9 : R2_W;

    // logical position to buffer slot, wraps once at most
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAPACITY))
        begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // point store
    logic [COORD_WIDTH-1:0] x_mem [CAPACITY];
    logic [COORD_WIDTH-1:0] y_mem [CAPACITY];

    // latched request
    logic [KIND_W-1:0]             kind_reg;
    logic signed [COORD_WIDTH-1:0] op_x_reg;
    logic signed [COORD_WIDTH-1:0] op_y_reg;
    logic [R2_W-1:0]               r2_reg;

    // store bookkeeping
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // walk pipeline
    logic [CNT_W-1:0]              issue_reg;
    logic                          s1_valid_reg;
    logic [CNT_W-1:0]              s1_idx_reg;
    logic signed [COORD_WIDTH-1:0] rd_x_reg, rd_y_reg;
    logic                          s2_valid_reg;
    logic signed [COORD_WIDTH-1:0] s2_x_reg, s2_y_reg;
    logic [SQ_W-1:0]               sqx_reg, sqy_reg;
    logic                          matched_reg;
    logic                          pend_valid_reg;
    logic signed [COORD_WIDTH-1:0] pend_x_reg, pend_y_reg;

    // output register
    logic                          out_valid_reg;
    logic [REPLY_W-1:0]            out_reply_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_y_reg;
    logic                          out_found_reg;
    logic [COUNT_W-1:0]            out_count_reg;
    logic [STATUS_W-1:0]           out_status_reg;
    logic                          out_last_reg;

    logic                          out_free, adv, issue, hit, in_range;
    logic                          emit_mid, fin, out_load;
    logic [IDX_W-1:0]              rd_addr;
    logic signed [SQ_W-1:0]        prod_x, prod_y;
    logic [SQ_W:0]                 d2;
    logic [CMP_W-1:0]              d2_scaled;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [COORD_WIDTH-1:0]        mem_wx, mem_wy;
    logic                          store_full, store_empty;
    logic [IDX_W-1:0]              head_dec;

    // final result fields
    logic [REPLY_W-1:0]            f_reply;
    logic signed [COORD_WIDTH-1:0] f_x, f_y;
    logic                          f_found;
    logic [STATUS_W-1:0]           f_status;

    // handshake and walk control
    assign out_free    = !out_valid_reg || !out_stall;
    assign store_empty = (count_reg == '0);
    assign store_full  = (count_reg == CNT_W'(CAPACITY));
    assign d2          = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign d2_scaled   = CMP_W'({d2, 8'b0});
    assign in_range    = (d2_scaled <= CMP_W'(r2_reg));
    // a second in-range point must wait for room in the output register
    assign adv         = !(s2_valid_reg && in_range && pend_valid_reg && !out_free);
    assign emit_mid    = cmd.scan && s2_valid_reg && in_range && pend_valid_reg && out_free;
    assign fin         = cmd.finish && out_free;
    assign out_load    = emit_mid || fin;
    assign issue       = cmd.scan && adv && (issue_reg < count_reg);
    assign rd_addr     = slot(head_reg, issue_reg);
    assign hit         = (rd_x_reg == op_x_reg) && (rd_y_reg == op_y_reg);
    assign prod_x      = rd_x_reg * rd_x_reg;
    assign prod_y      = rd_y_reg * rd_y_reg;
    assign head_dec    = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - 1'b1;

    assign status.empty     = store_empty;
    assign status.scan_done = (issue_reg == count_reg) && !s1_valid_reg && !s2_valid_reg;
    assign status.out_free  = out_free;

    // store write: push at the front, or compaction behind a deleted match
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = head_dec;
        mem_wx    = op_x_reg;
        mem_wy    = op_y_reg;
        if (fin && (kind_reg == KIND_PUSH) && !store_full)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.scan && adv && s1_valid_reg && (kind_reg == KIND_DELETE) && matched_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = slot(head_reg, s1_idx_reg - 1'b1);
            mem_wx    = rd_x_reg;
            mem_wy    = rd_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[mem_waddr] <= mem_wx;
            y_mem[mem_waddr] <= mem_wy;
        end
        if (issue)
        begin
            rd_x_reg <= x_mem[rd_addr];
            rd_y_reg <= y_mem[rd_addr];
        end
    end

    // closing result and store update
    always_comb
    begin
        f_reply    = REPLY_ACK;
        f_x        = '0;
        f_y        = '0;
        f_found    = 1'b0;
        f_status   = STAT_OK;
        head_next  = head_reg;
        count_next = count_reg;
        case (kind_reg)
            KIND_PUSH:
            begin
                if (store_full)
                begin
                    f_status = STAT_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP:
            begin
                if (store_empty)
                begin
                    f_status = STAT_EMPTY;
                end
                else
                begin
                    head_next  = slot(head_reg, CNT_W'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_DELETE:
            begin
                if (store_empty)
                begin
                    f_status = STAT_EMPTY;
                end
                else if (matched_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    f_status = STAT_NOMATCH;
                end
            end
            KIND_QUERY:
            begin
                if (pend_valid_reg)
                begin
                    f_reply = REPLY_IN_RANGE;
                    f_x     = pend_x_reg;
                    f_y     = pend_y_reg;
                end
                else
                begin
                    f_reply  = REPLY_NONE;
                    f_status = store_empty ? STAT_EMPTY : STAT_OK;
                end
            end
            KIND_FIND:
            begin
                f_reply  = REPLY_FIND;
                f_found  = matched_reg;
                f_status = store_empty ? STAT_EMPTY : STAT_OK;
            end
            KIND_COUNT:
            begin
                f_reply = REPLY_COUNT;
            end
            default:
            begin
                f_reply = REPLY_ACK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            issue_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            matched_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fin)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end

            if (cmd.load)
            begin
                issue_reg      <= '0;
                s1_valid_reg   <= 1'b0;
                s2_valid_reg   <= 1'b0;
                matched_reg    <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                if (adv)
                begin
                    s1_valid_reg <= issue;
                    s2_valid_reg <= s1_valid_reg && (kind_reg == KIND_QUERY);
                end
                // first equal point wins
                if (cmd.scan && adv && s1_valid_reg && hit &&
                    ((kind_reg == KIND_DELETE) || (kind_reg == KIND_FIND)))
                begin
                    matched_reg <= 1'b1;
                end
                if (cmd.scan && adv && s2_valid_reg && in_range)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            op_x_reg <= x_coord;
            op_y_reg <= y_coord;
            r2_reg   <= R2_W'(radius) * R2_W'(radius);
        end
        if (adv)
        begin
            s1_idx_reg <= issue_reg;
            s2_x_reg   <= rd_x_reg;
            s2_y_reg   <= rd_y_reg;
            sqx_reg    <= $unsigned(prod_x);
            sqy_reg    <= $unsigned(prod_y);
        end
        if (cmd.scan && adv && s2_valid_reg && in_range)
        begin
            pend_x_reg <= s2_x_reg;
            pend_y_reg <= s2_y_reg;
        end
        if (emit_mid)
        begin
            out_reply_reg  <= REPLY_IN_RANGE;
            out_x_reg      <= pend_x_reg;
            out_y_reg      <= pend_y_reg;
            out_found_reg  <= 1'b0;
            out_count_reg  <= COUNT_W'(count_reg);
            out_status_reg <= STAT_OK;
            out_last_reg   <= 1'b0;
        end
        else if (fin)
        begin
            out_reply_reg  <= f_reply;
            out_x_reg      <= f_x;
            out_y_reg      <= f_y;
            out_found_reg  <= f_found;
            out_count_reg  <= COUNT_W'(count_next);
            out_status_reg <= f_status;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign reply       = out_reply_reg;
    assign x_out       = out_x_reg;
    assign y_out       = out_y_reg;
    assign found       = out_found_reg;
    assign count       = out_count_reg;
    assign status_code = out_status_reg;
    assign last        = out_last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_idx_reg < count_reg))
        else $error("walk read past the stored entries");

    a_square_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (kind_reg == KIND_QUERY))
        else $error("radius stage busy outside a radius query");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("output register loaded while a result is held");

endmodule
